// ===== rtl/core/crbr_pkg.sv =====
// Shared types and constants for the row bias load and requantize core.
package crbr_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD_BIAS    = 2'd0,
        ACT_LOAD_PARTIAL = 2'd1,
        ACT_STORE        = 2'd2
    } t_action;

    typedef struct packed {
        t_action            action;
        logic signed [5:0]  shift;
        logic        [3:0]  frac_in;
        logic               last_chan;
        logic               last_layer;
    } t_lane_ctrl;

    localparam logic [2:0] REG_FRAC_IN    = 3'd0;
    localparam logic [2:0] REG_FRAC_WEI   = 3'd1;
    localparam logic [2:0] REG_FRAC_OUT   = 3'd2;
    localparam logic [2:0] REG_STRIDE_TWO = 3'd3;
    localparam logic [2:0] REG_LAST_LAYER = 3'd4;

    localparam logic [3:0] FRAC_RESET = 4'd8;

    localparam int SAT8_HI  = 127;
    localparam int SAT8_LO  = -128;
    localparam int SAT16_HI = 32767;
    localparam int SAT16_LO = -32768;

endpackage

// ===== rtl/core/conv_row_bias_load_and_requantize_core.sv =====
// Top level of the row bias load and requantize core.
//
//  channel   dir  handshake              payload
//  s stream  in   i_s_tvalid/o_s_tready  tdata lanes+bias, tuser action+odd, tlast last chan
//  m stream  out  o_m_tvalid/i_m_tready  tdata out lanes, tuser write mask
//  config    in   psel/penable/pwrite    APB, five registers at 4*i, pready tied high
//
// One row per cycle unless the output stalls; rows pass input, then result register.
// All lane work sits between those two registers, one lane unit per lane.
// Reset clears both valid flags and returns the config registers to their reset values.
// A stalled result holds; an empty input register still fills while the result waits.
module conv_row_bias_load_and_requantize_core
    import crbr_pkg::*;
#(
    parameter int LANES     = 8,
    parameter int ACC_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // lane_0 .. lane_(LANES-1) (32 each), bias (8)
    input  logic [LANES*32+7:0]   i_s_tdata,
    // action (2), odd_column (1)
    input  logic [2:0]            i_s_tuser,
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // out_lane_0 .. out_lane_(LANES-1) (32 each)
    output logic [LANES*32-1:0]   o_m_tdata,
    // write_mask (8)
    output logic [7:0]            o_m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int HALF = LANES / 2;

    logic [3:0] r_frac_in, r_frac_wei, r_frac_out;
    logic       r_stride_two, r_last_layer;

    logic                  r_s1_valid;
    logic [LANES*32+7:0]   r_s1_data;
    logic [2:0]            r_s1_user;
    logic                  r_s1_last;

    logic                  r_m_valid;
    logic [LANES*32-1:0]   r_m_data;
    logic [LANES-1:0]      r_m_mask;

    logic                  w_out_free;
    logic                  w_s1_move;
    logic                  w_cfg_wr;
    logic [2:0]            w_cfg_idx;
    t_lane_ctrl            w_ctrl;
    logic                  w_odd;
    logic [31:0]           w_res  [LANES];
    logic [LANES*32-1:0]   n_m_data;
    logic [LANES-1:0]      n_m_mask;
    logic [LANES-1:0]      w_stray;

    // configuration port
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_in    <= FRAC_RESET;
            r_frac_wei   <= FRAC_RESET;
            r_frac_out   <= FRAC_RESET;
            r_stride_two <= 1'b0;
            r_last_layer <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_FRAC_IN:    r_frac_in    <= pwdata[3:0];
                REG_FRAC_WEI:   r_frac_wei   <= pwdata[3:0];
                REG_FRAC_OUT:   r_frac_out   <= pwdata[3:0];
                REG_STRIDE_TWO: r_stride_two <= pwdata[0];
                REG_LAST_LAYER: r_last_layer <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_FRAC_IN:    prdata = 32'(r_frac_in);
            REG_FRAC_WEI:   prdata = 32'(r_frac_wei);
            REG_FRAC_OUT:   prdata = 32'(r_frac_out);
            REG_STRIDE_TWO: prdata = 32'(r_stride_two);
            REG_LAST_LAYER: prdata = 32'(r_last_layer);
            default:        prdata = '0;
        endcase
    end

    // pipeline handshake
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_s_tready = !r_s1_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_s1_data <= i_s_tdata;
            r_s1_user <= i_s_tuser;
            r_s1_last <= i_s_tlast;
        end
    end

    // lane control shared by all lane units
    always_comb begin
        w_ctrl.action     = t_action'(r_s1_user[1:0]);
        w_ctrl.shift      = 6'(r_frac_in) + 6'(r_frac_wei) - 6'(r_frac_out);
        w_ctrl.frac_in    = r_frac_in;
        w_ctrl.last_chan  = r_s1_last;
        w_ctrl.last_layer = r_last_layer;
    end
    assign w_odd = r_s1_user[2];

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        localparam int  LD_LO  = k / 2;
        localparam int  LD_HI  = k / 2 + HALF;
        localparam bit  LD_EVN = (k % 2) == 0;
        localparam bit  ST_LOK = k < HALF;
        localparam bit  ST_HOK = (k >= HALF) && (k < 2 * HALF);
        localparam int  ST_LO  = ST_LOK ? 2 * k : 0;
        localparam int  ST_HI  = ST_HOK ? 2 * (k - HALF) : 0;

        logic [31:0] w_ld_src;
        logic [31:0] w_st_src;
        logic        w_ld_wr;
        logic        w_st_wr;
        logic        w_wr;
        logic [31:0] w_value;

        assign w_ld_src = !r_stride_two ? r_s1_data[32*k +: 32] :
                          (w_odd ? r_s1_data[32*LD_HI +: 32] : r_s1_data[32*LD_LO +: 32]);
        assign w_st_src = !r_stride_two ? r_s1_data[32*k +: 32] :
                          (w_odd ? r_s1_data[32*ST_HI +: 32] : r_s1_data[32*ST_LO +: 32]);
        assign w_ld_wr  = !r_stride_two || LD_EVN;
        assign w_st_wr  = !r_stride_two || (w_odd ? ST_HOK : ST_LOK);

        crbr_lane #(
            .ACC_WIDTH (ACC_WIDTH)
        ) u_lane (
            .i_ctrl      (w_ctrl),
            .i_load_val  (w_ld_src),
            .i_store_val (w_st_src),
            .i_bias      ($signed(r_s1_data[LANES*32 +: 8])),
            .o_value     (w_value)
        );

        always_comb begin
            unique case (w_ctrl.action)
                ACT_LOAD_BIAS, ACT_LOAD_PARTIAL: w_wr = w_ld_wr;
                ACT_STORE:                       w_wr = w_st_wr;
                default:                         w_wr = 1'b0;
            endcase
        end

        assign n_m_mask[k]          = w_wr;
        assign w_res[k]             = n_m_mask[k] ? w_value : 32'd0;
        assign n_m_data[32*k +: 32] = w_res[k];
        // unwritten lanes must read as zero
        assign w_stray[k] = !r_m_mask[k] && (r_m_data[32*k +: 32] != 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_free) begin
            r_m_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_m_data <= n_m_data;
            r_m_mask <= n_m_mask;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = 8'(r_m_mask);

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_s1_valid)
        else $error("accepted transaction not held in input register");

    a_result_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_tready) |=> (r_m_valid && $stable(r_m_mask)))
        else $error("stalled result dropped or changed");

    a_stride_lane_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_stride_two) |-> ($countones(r_m_mask) <= (LANES + 1) / 2))
        else $error("stride-2 result writes too many lanes");

    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_stray == '0))
        else $error("lane outside write mask is not zero");

endmodule

// ===== rtl/core/crbr_lane.sv =====
// One lane of load scaling and store rounding, clamping and saturation.
module crbr_lane
    import crbr_pkg::*;
#(
    parameter int ACC_WIDTH = 32
) (
    input  t_lane_ctrl         i_ctrl,
    input  logic        [31:0] i_load_val,
    input  logic        [31:0] i_store_val,
    input  logic signed [7:0]  i_bias,
    output logic        [31:0] o_value
);

    localparam logic signed [ACC_WIDTH-1:0] C_I8_MAX  = ACC_WIDTH'(SAT8_HI);
    localparam logic signed [ACC_WIDTH-1:0] C_I8_MIN  = ACC_WIDTH'(SAT8_LO);
    localparam logic signed [ACC_WIDTH-1:0] C_I16_MAX = ACC_WIDTH'(SAT16_HI);
    localparam logic signed [ACC_WIDTH-1:0] C_I16_MIN = ACC_WIDTH'(SAT16_LO);

    logic                        w_sh_neg;
    logic                        w_sh_pos;
    logic signed [5:0]           w_sh_negated;
    logic        [4:0]           w_sh_mag;
    logic signed [ACC_WIDTH-1:0] w_bias_acc;
    logic signed [ACC_WIDTH-1:0] w_part_ext;
    logic signed [ACC_WIDTH-1:0] w_part;
    logic signed [ACC_WIDTH-1:0] w_acc;
    logic        [ACC_WIDTH-1:0] w_rnd;
    logic signed [ACC_WIDTH-1:0] w_sum;
    logic signed [ACC_WIDTH-1:0] w_scaled;
    logic signed [ACC_WIDTH-1:0] w_clamped;

    assign w_sh_neg     = i_ctrl.shift[5];
    assign w_sh_pos     = !w_sh_neg && (i_ctrl.shift != 6'sd0);
    assign w_sh_negated = -i_ctrl.shift;
    assign w_sh_mag     = w_sh_neg ? w_sh_negated[4:0] : i_ctrl.shift[4:0];

    assign w_bias_acc = ACC_WIDTH'(i_bias) <<< i_ctrl.frac_in;

    assign w_part_ext = ACC_WIDTH'($signed(i_load_val[15:0]));
    assign w_part     = w_sh_neg ? (w_part_ext >>> w_sh_mag) : (w_part_ext <<< w_sh_mag);

    // rounding term drops out once it lies beyond the accumulator width
    assign w_acc    = ACC_WIDTH'($signed(i_store_val));
    assign w_rnd    = {{(ACC_WIDTH-1){1'b0}}, 1'b1} << (w_sh_mag - 5'd1);
    assign w_sum    = ACC_WIDTH'(w_acc + w_rnd);
    assign w_scaled = w_sh_pos ? (w_sum >>> w_sh_mag) : (w_acc <<< w_sh_mag);

    always_comb begin
        w_clamped = w_scaled;
        if (i_ctrl.last_chan) begin
            if (i_ctrl.last_layer) begin
                if (w_clamped < C_I8_MIN) w_clamped = C_I8_MIN;
            end else if (w_clamped < 0) begin
                w_clamped = '0;
            end
            if (w_clamped > C_I8_MAX) w_clamped = C_I8_MAX;
        end
        if (w_clamped > C_I16_MAX) w_clamped = C_I16_MAX;
        if (w_clamped < C_I16_MIN) w_clamped = C_I16_MIN;
    end

    always_comb begin
        unique case (i_ctrl.action)
            ACT_LOAD_BIAS:    o_value = 32'(w_bias_acc);
            ACT_LOAD_PARTIAL: o_value = 32'(w_part);
            ACT_STORE:        o_value = 32'($signed(w_clamped[15:0]));
            default:          o_value = '0;
        endcase
    end

endmodule

// ===== dv/tb_conv_row_bias_load_and_requantize_core.sv =====
// Self-checking regression for the row bias load and requantize core.
module tb_conv_row_bias_load_and_requantize_core;
    import crbr_pkg::*;

    localparam int LANES          = 8;
    localparam int CLK_PERIOD     = 20;
    localparam int TIMEOUT_CYCLES = 300000;
    localparam int LONG_HOLD      = 200;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_ROWS     = 92;

    // action code with no operation behind it
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]             action;
        logic [LANES-1:0][31:0] lane;
        logic [7:0]             bias;
        logic                   last_chan;
        logic                   odd_col;
    } t_row_item;

    typedef struct packed {
        logic [LANES-1:0][31:0] lane;
        logic [7:0]             mask;
    } t_row_result;

    // lane 7 first (highest bits)
    localparam logic [LANES-1:0][31:0] CORNER_LANES = {
        32'h12345678, 32'h00000001, 32'hFFFFFFFF, 32'h00000000,
        32'hFFFF7FFF, 32'h00008000, 32'h80000000, 32'h7FFFFFFF
    };
    // values around rounding ties and the 8-bit and 16-bit limits
    localparam logic [LANES-1:0][31:0] TIE_LANES = {
        32'h00007F80, 32'hFFFF8080, 32'h00800000, 32'hFF800000,
        32'hFFFFFF7F, 32'hFFFFFF80, 32'h0000017F, 32'h00000080
    };

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [LANES*32+7:0]    s_tdata  = '0;
    logic [2:0]             s_tuser  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   o_m_tvalid;
    logic                   m_tready = 1'b0;
    logic [LANES*32-1:0]    o_m_tdata;
    logic [7:0]             o_m_tuser;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [4:0]             paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // layer settings as the block should hold them
    logic [3:0] cfg_frac_in    = FRAC_RESET;
    logic [3:0] cfg_frac_wei   = FRAC_RESET;
    logic [3:0] cfg_frac_out   = FRAC_RESET;
    logic       cfg_stride_two = 1'b0;
    logic       cfg_last_layer = 1'b0;

    t_row_item   rows_to_send[$];
    t_row_result rows_due[$];
    t_row_item   row_on_bus;
    int          rows_loaded     = 0;
    int          rows_taken      = 0;
    int          results_seen    = 0;
    int          mismatch_count  = 0;
    int          src_wait        = 0;
    int          snk_wait        = 0;
    int          hold_left       = 0;
    int          hold_requests   = 0;
    int          holds_done      = 0;
    logic        src_idle_en     = 1'b1;
    logic        snk_idle_en     = 1'b1;

    conv_row_bias_load_and_requantize_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // lane_0 .. lane_7 (32 each), bias (8)
        .i_s_tuser  (s_tuser),      // action (2), odd_column (1)
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),    // out_lane_0 .. out_lane_7 (32 each)
        .o_m_tuser  (o_m_tuser),    // write_mask (8)
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic longint sext32(longint x);
        return longint'($signed(x[31:0]));
    endfunction

    function automatic int layer_shift();
        return int'(cfg_frac_in) + int'(cfg_frac_wei) - int'(cfg_frac_out);
    endfunction

    // Round and shift down (shift up for a negative shift), clamp for one stored lane.
    function automatic longint requantize_lane(longint acc, int sh, logic last_ch);
        longint v;
        if (sh >= 1) begin
            v = sext32(acc + (longint'(1) << (sh - 1)));
            v = v >>> sh;
        end else begin
            v = sext32(acc << (-sh));
        end
        if (last_ch) begin
            if (cfg_last_layer) begin
                if (v < SAT8_LO) v = SAT8_LO;
            end else if (v < 0) begin
                v = 0;
            end
            if (v > SAT8_HI) v = SAT8_HI;
        end
        if (v > SAT16_HI) v = SAT16_HI;
        if (v < SAT16_LO) v = SAT16_LO;
        return v;
    endfunction

    function automatic t_row_result requantize_row(t_row_item it);
        t_row_result r;
        int          sh;
        int          half_base;
        int          src;
        int          k;
        longint      v;
        r = '0;
        sh = layer_shift();
        half_base = it.odd_col ? LANES / 2 : 0;
        case (it.action)
            ACT_LOAD_BIAS, ACT_LOAD_PARTIAL: begin
                for (k = 0; k < LANES; k++) begin
                    // stride 2 writes only even lanes
                    if (!(cfg_stride_two && (k % 2 == 1))) begin
                        src = cfg_stride_two ? k / 2 + half_base : k;
                        if (it.action == ACT_LOAD_BIAS) begin
                            v = sext32(longint'($signed(it.bias)) << cfg_frac_in);
                        end else begin
                            v = longint'($signed(it.lane[src][15:0]));
                            v = (sh >= 0) ? sext32(v << sh) : (v >>> (-sh));
                        end
                        r.lane[k] = v[31:0];
                        r.mask[k] = 1'b1;
                    end
                end
            end
            ACT_STORE: begin
                if (cfg_stride_two) begin
                    for (k = 0; k < LANES / 2; k++) begin
                        v = requantize_lane(sext32(longint'(it.lane[2 * k])), sh, it.last_chan);
                        r.lane[half_base + k] = v[31:0];
                        r.mask[half_base + k] = 1'b1;
                    end
                end else begin
                    for (k = 0; k < LANES; k++) begin
                        v = requantize_lane(sext32(longint'(it.lane[k])), sh, it.last_chan);
                        r.lane[k] = v[31:0];
                        r.mask[k] = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("mismatch: %s", what);
    endtask

    // Driver: present rows from the pending queue, predict at each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                rows_due.push_back(requantize_row(row_on_bus));
                rows_taken++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end else if (rows_to_send.size() != 0) begin
                    row_on_bus = rows_to_send.pop_front();
                    s_tdata  <= {row_on_bus.bias, row_on_bus.lane};
                    s_tuser  <= {row_on_bus.odd_col, row_on_bus.action};
                    s_tlast  <= row_on_bus.last_chan;
                    s_tvalid <= 1'b1;
                    src_wait = src_idle_en ? $urandom_range(0, 14) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_row_result want;
        int          k;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (rows_due.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                            results_seen));
                end else begin
                    want = rows_due.pop_front();
                    for (k = 0; k < LANES; k++) begin
                        if (o_m_tdata[32*k +: 32] !== want.lane[k])
                            flag_mismatch($sformatf("result %0d lane %0d: got %h, want %h",
                                results_seen, k, o_m_tdata[32*k +: 32], want.lane[k]));
                    end
                    if (o_m_tuser !== want.mask)
                        flag_mismatch($sformatf("result %0d write mask: got %h, want %h",
                                                results_seen, o_m_tuser, want.mask));
                end
                results_seen++;
                snk_wait = snk_idle_en ? $urandom_range(0, 14) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (holds_done < hold_requests) begin
                // back-pressure long enough to fill the block and stall its input
                holds_done++;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (snk_wait > 0) begin
                snk_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAC_IN:    cfg_frac_in    = val[3:0];
            REG_FRAC_WEI:   cfg_frac_wei   = val[3:0];
            REG_FRAC_OUT:   cfg_frac_out   = val[3:0];
            REG_STRIDE_TWO: cfg_stride_two = val[0];
            REG_LAST_LAYER: cfg_last_layer = val[0];
            default: begin
            end
        endcase
    endtask

    // Upper register bits get random junk; the block keeps only the low field.
    task automatic set_layer(logic [3:0] fi, logic [3:0] fw, logic [3:0] fo,
                             logic st, logic ll);
        write_reg(REG_FRAC_IN,    {28'($urandom), fi});
        write_reg(REG_FRAC_WEI,   {28'($urandom), fw});
        write_reg(REG_FRAC_OUT,   {28'($urandom), fo});
        write_reg(REG_STRIDE_TWO, {31'($urandom), st});
        write_reg(REG_LAST_LAYER, {31'($urandom), ll});
    endtask

    // Hold the sender until every prediction has been matched.
    task automatic drain_rows();
        while (rows_taken != rows_loaded || rows_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_row(t_row_item it);
        rows_to_send.push_back(it);
        rows_loaded++;
    endtask

    function automatic t_row_item make_row(logic [1:0] act, logic [LANES-1:0][31:0] ln,
                                           logic [7:0] b, logic lc, logic oc);
        t_row_item it;
        it.action    = act;
        it.lane      = ln;
        it.bias      = b;
        it.last_chan = lc;
        it.odd_col   = oc;
        return it;
    endfunction

    function automatic logic [31:0] pick_acc(int sh);
        int mag;
        int sc;
        sc = (sh > 1) ? sh - 1 : 0;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFFFFFF;
                    1:       return 32'h80000000;
                    2:       return 32'hFFFFFFFF;
                    default: return 32'h00000000;
                endcase
            end
            2: begin
                mag = int'($urandom >> $urandom_range(0, 31));
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: begin
                // land near rounding ties and the clamp limits
                mag = int'($urandom_range(0, 700)) - 350;
                return (mag <<< sc) + int'($urandom_range(0, 2)) - 1;
            end
        endcase
    endfunction

    function automatic t_row_item random_row();
        t_row_item it;
        int        pick;
        int        sh;
        int        k;
        pick = $urandom_range(0, 15);
        sh = layer_shift();
        if (pick < 4)       it.action = ACT_LOAD_BIAS;
        else if (pick < 8)  it.action = ACT_LOAD_PARTIAL;
        else if (pick < 15) it.action = ACT_STORE;
        else                it.action = ACT_NONE;
        for (k = 0; k < LANES; k++) it.lane[k] = pick_acc(sh);
        it.bias      = 8'($urandom);
        it.last_chan = 1'($urandom_range(0, 1));
        it.odd_col   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    initial begin
        int p;
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, shift of 8
        queue_row(make_row(ACT_LOAD_BIAS, CORNER_LANES, 8'h7F, 1'b0, 1'b0));
        queue_row(make_row(ACT_LOAD_BIAS, CORNER_LANES, 8'h80, 1'b1, 1'b1));
        queue_row(make_row(ACT_LOAD_PARTIAL, CORNER_LANES, 8'h00, 1'b0, 1'b0));
        queue_row(make_row(ACT_STORE, CORNER_LANES, 8'h00, 1'b0, 1'b0));
        queue_row(make_row(ACT_STORE, CORNER_LANES, 8'h00, 1'b1, 1'b0));
        queue_row(make_row(ACT_STORE, TIE_LANES, 8'h00, 1'b1, 1'b0));
        queue_row(make_row(ACT_NONE, '1, 8'hFF, 1'b1, 1'b1));
        drain_rows();
        // largest shift, wraps on loads
        set_layer(4'd15, 4'd15, 4'd0, 1'b0, 1'b0);
        queue_row(make_row(ACT_LOAD_BIAS, CORNER_LANES, 8'h7F, 1'b0, 1'b0));
        queue_row(make_row(ACT_LOAD_PARTIAL, CORNER_LANES, 8'h80, 1'b0, 1'b0));
        queue_row(make_row(ACT_STORE, CORNER_LANES, 8'h00, 1'b0, 1'b0));
        drain_rows();
        // negative shift: right shift on load, left shift on store
        set_layer(4'd0, 4'd0, 4'd15, 1'b0, 1'b1);
        queue_row(make_row(ACT_LOAD_PARTIAL, CORNER_LANES, 8'h00, 1'b0, 1'b0));
        queue_row(make_row(ACT_STORE, CORNER_LANES, 8'h00, 1'b1, 1'b0));
        queue_row(make_row(ACT_STORE, TIE_LANES, 8'h00, 1'b1, 1'b0));
        drain_rows();
        // zero shift drops the rounding term
        set_layer(4'd4, 4'd4, 4'd8, 1'b0, 1'b0);
        queue_row(make_row(ACT_STORE, CORNER_LANES, 8'h00, 1'b0, 1'b0));
        queue_row(make_row(ACT_STORE, TIE_LANES, 8'h00, 1'b1, 1'b0));
        drain_rows();
        // stride 2 remapping on both halves, last-layer floor
        set_layer(4'd8, 4'd8, 4'd8, 1'b1, 1'b1);
        queue_row(make_row(ACT_LOAD_BIAS, CORNER_LANES, 8'h80, 1'b0, 1'b1));
        queue_row(make_row(ACT_LOAD_PARTIAL, CORNER_LANES, 8'h00, 1'b0, 1'b0));
        queue_row(make_row(ACT_LOAD_PARTIAL, CORNER_LANES, 8'h00, 1'b0, 1'b1));
        queue_row(make_row(ACT_STORE, TIE_LANES, 8'h00, 1'b1, 1'b0));
        queue_row(make_row(ACT_STORE, CORNER_LANES, 8'h00, 1'b0, 1'b1));
        queue_row(make_row(ACT_NONE, CORNER_LANES, 8'h00, 1'b0, 1'b1));

        for (p = 0; p < RAND_PHASES; p++) begin
            drain_rows();
            case (p)
                0:       set_layer(4'd15, 4'd15, 4'd15, 1'b0, 1'b0);
                1:       set_layer(4'd0, 4'd0, 4'd0, 1'b1, 1'b1);
                2:       set_layer(4'd15, 4'd0, 4'd15, 1'b0, 1'b1);
                default: set_layer(4'($urandom), 4'($urandom), 4'($urandom),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            src_idle_en = (p % 4 != 3) && (p != 5);
            snk_idle_en = (p % 4 != 3);
            for (n = 0; n < PHASE_ROWS; n++) queue_row(random_row());
            if (p == 5) hold_requests++;
        end

        drain_rows();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("conv_row_bias_load_and_requantize_core regression: pass");
        end else begin
            $display("conv_row_bias_load_and_requantize_core regression: fail");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("conv_row_bias_load_and_requantize_core regression: fail");
        $finish;
    end

endmodule

// ===== conv_row_bias_load_and_requantize_core.f =====
rtl/core/crbr_pkg.sv
rtl/core/crbr_lane.sv
rtl/core/conv_row_bias_load_and_requantize_core.sv
dv/tb_conv_row_bias_load_and_requantize_core.sv
